// ----- rtl/core/tcw_pkg.sv -----
// shared types, codes and cell helpers for the text console writer
// no dependencies; imported by every module of the block
package tcw_pkg;

  localparam int unsigned TCW_COLUMNS = 80;
  localparam int unsigned TCW_ROWS    = 25;

  localparam int unsigned CELL_W = 16;
  typedef logic [CELL_W-1:0] cell_t;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam cell_t      BG_KEEP_MASK = 16'hF000;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PUT_ADDR,
    S_PUT_WR,
    S_SCROLL,
    S_FILL,
    S_READ,
    S_DONE
  } state_e;

  typedef struct packed {
    req_e        req_type;
    logic [7:0]  char_code;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;
    logic [10:0] cell_index;
  } req_t;

  typedef struct packed {
    cell_t       cell_data;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
  } result_t;

  // attribute byte is bg over fg, character byte below
  function automatic cell_t make_cell(logic [3:0] bg, logic [3:0] fg, logic [7:0] ch);
    return {bg, fg, ch};
  endfunction

  // clear fill: background nibble and a space
  function automatic cell_t fill_cell(logic [3:0] bg);
    return {bg, 4'h0, SPACE_CODE};
  endfunction

  // bottom row after a scroll keeps its old background nibble
  function automatic cell_t blank_cell(cell_t c);
    return (c & BG_KEEP_MASK) | {8'h00, SPACE_CODE};
  endfunction

endpackage

// ----- rtl/core/tcw_cell_ram.sv -----
// screen cell store: one write port, one read port with registered data
// depends on tcw_pkg for the cell type
module tcw_cell_ram #(
  parameter int unsigned Depth = tcw_pkg::TCW_COLUMNS * tcw_pkg::TCW_ROWS,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  tcw_pkg::cell_t    wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output tcw_pkg::cell_t    rdata_o
);
  import tcw_pkg::*;

  cell_t mem [Depth];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/tcw_engine.sv -----
// request sequencer: cursor, put address unit, scroll/clear sweeps over the cell store
// depends on tcw_pkg and tcw_cell_ram
module tcw_engine #(
  parameter int unsigned Columns = tcw_pkg::TCW_COLUMNS,
  parameter int unsigned Rows    = tcw_pkg::TCW_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcw_pkg::req_t     req_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output tcw_pkg::result_t  res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);
  import tcw_pkg::*;

  localparam int unsigned Cells = Columns * Rows;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned RW    = $clog2(Rows);
  localparam int unsigned CW    = $clog2(Columns);
  localparam logic [AW-1:0] LastCell = AW'(Cells - 1);
  localparam logic [AW-1:0] RowSpan  = AW'(Columns);
  localparam logic [AW-1:0] LastRow0 = AW'(Cells - Columns);
  localparam logic [RW-1:0] BottomRow = RW'(Rows - 1);
  localparam logic [CW-1:0] LastCol   = CW'(Columns - 1);

  state_e        state_q, state_d;
  req_t          req_q, req_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] src_q, src_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          blank_q, blank_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic          pend_blank_q, pend_blank_d;
  logic          scrolled_q, scrolled_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  cell_t         ram_wdata, ram_rdata;

  logic is_nl, next_line, row_last, need_scroll, rd_hit, src_last;

  tcw_cell_ram #(
    .Depth (Cells),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign is_nl       = (req_q.char_code == NEWLINE_CODE);
  assign next_line   = is_nl || (col_q == LastCol);
  assign row_last    = (row_q == BottomRow);
  assign need_scroll = next_line && row_last;
  assign rd_hit      = (int'(req_q.cell_index) < int'(Cells));
  assign src_last    = (src_q == LastCell);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:     if (src_last) state_d = S_IDLE;
      S_IDLE: begin
        if (req_valid_i) begin
          unique case (req_i.req_type)
            REQ_PUT:   state_d = S_PUT_ADDR;
            REQ_CLEAR: state_d = S_FILL;
            REQ_READ:  state_d = S_READ;
            REQ_NONE:  state_d = S_DONE;
          endcase
        end
      end
      S_PUT_ADDR: state_d = S_PUT_WR;
      S_PUT_WR:   state_d = need_scroll ? S_SCROLL : S_DONE;
      S_SCROLL:   if (blank_q && src_last) state_d = S_DONE;
      S_FILL:     if (src_last) state_d = S_DONE;
      S_READ:     state_d = S_DONE;
      S_DONE:     if (res_ready_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    req_d        = req_q;
    row_d        = row_q;
    col_d        = col_q;
    src_d        = src_q;
    addr_d       = addr_q;
    blank_d      = blank_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    pend_blank_d = pend_blank_q;
    scrolled_d   = scrolled_q;
    ram_we       = 1'b0;
    ram_waddr    = src_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = src_q;

    // delayed write of a scroll read
    if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = pend_blank_q ? blank_cell(ram_rdata) : ram_rdata;
    end

    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = src_q;
        ram_wdata = '0;
        src_d     = src_q + AW'(1);
      end
      S_IDLE: begin
        if (req_valid_i) begin
          req_d      = req_i;
          scrolled_d = 1'b0;
          src_d      = '0;
        end
      end
      S_PUT_ADDR: begin
        addr_d = AW'(int'(row_q) * int'(Columns) + int'(col_q));
      end
      S_PUT_WR: begin
        if (!is_nl) begin
          ram_we    = 1'b1;
          ram_waddr = addr_q;
          ram_wdata = make_cell(req_q.bg_color, req_q.fg_color, req_q.char_code);
        end
        col_d = next_line ? '0 : col_q + CW'(1);
        if (next_line && !row_last) begin
          row_d = row_q + RW'(1);
        end
        scrolled_d = need_scroll;
        src_d      = RowSpan;
        blank_d    = 1'b0;
      end
      S_SCROLL: begin
        ram_re       = 1'b1;
        ram_raddr    = src_q;
        pend_d       = 1'b1;
        pend_blank_d = blank_q;
        pend_addr_d  = blank_q ? src_q : src_q - RowSpan;
        if (src_last) begin
          if (!blank_q) begin
            blank_d = 1'b1;
            src_d   = LastRow0;
          end
        end else begin
          src_d = src_q + AW'(1);
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = src_q;
        ram_wdata = fill_cell(req_q.bg_color);
        src_d     = src_q + AW'(1);
        if (src_last) begin
          row_d = '0;
          col_d = '0;
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(req_q.cell_index);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      row_q      <= '0;
      col_q      <= '0;
      src_q      <= '0;
      blank_q    <= 1'b0;
      pend_q     <= 1'b0;
      scrolled_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      src_q      <= src_d;
      blank_q    <= blank_d;
      pend_q     <= pend_d;
      scrolled_q <= scrolled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    addr_q       <= addr_d;
    pend_addr_q  <= pend_addr_d;
    pend_blank_q <= pend_blank_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.cell_data  = (req_q.req_type == REQ_READ && rd_hit) ? ram_rdata : '0;
    res_o.cursor_row = 5'(row_q);
    res_o.cursor_col = 7'(col_q);
    res_o.scrolled   = scrolled_q;
  end

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= BottomRow)
    else $error("cursor row beyond bottom row");

  a_scroll_lands_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.scrolled |-> row_q == BottomRow && col_q == '0)
    else $error("scroll result without cursor at start of bottom row");

  a_clear_homes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL && src_last |=> row_q == '0 && col_q == '0)
    else $error("clear did not home the cursor");

  a_no_write_left_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_q)
    else $error("scroll write still pending in idle");

endmodule

// ----- rtl/core/text_console_writer.sv -----
// text console writer top level: stream ports, request unpacking, result register
// depends on tcw_pkg and tcw_engine
//
// Text-mode screen store of ROWS x COLUMNS 16-bit cells (attribute byte of
// bg<<4|fg over the character byte) with a cursor. Requests arrive on the
// slave stream with the request kind in tuser (0 put character, 1 clear,
// 2 read cell, 3 no operation); every request gives exactly one result
// transfer on the master stream carrying the cell read (zero otherwise), the
// cursor after the request and a scrolled flag. One request is worked at a
// time; the next is taken as soon as the sequencer is back to idle, even
// while the previous result still waits in the output register. A put
// character steps through address multiply, store write and result; a
// read goes through a registered store read; a clear writes one cell per
// cycle. A put that runs past the bottom row adds a scroll sweep: the
// single store port pair reads one cell a cycle and writes it one row up,
// then rewrites the bottom row to spaces keeping each cell's background
// nibble. After reset the block clears the store to zero, one cell a
// cycle, before the first request is accepted.
module text_console_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::TCW_COLUMNS,
  parameter int unsigned ROWS    = tcw_pkg::TCW_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // char_code[7:0], fg_color[11:8], bg_color[15:12], cell_index[26:16], zero above
  input  logic [31:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // cell_data[15:0], cursor_row[20:16], cursor_col[27:21], scrolled[28], zero above
  output logic [31:0] m_axis_tdata_o
);
  import tcw_pkg::*;

  req_t    req;
  result_t res;
  logic    res_valid, res_ready;

  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;

  // unpack the request transfer
  always_comb begin
    req.req_type   = req_e'(s_axis_tuser_i);
    req.char_code  = s_axis_tdata_i[7:0];
    req.fg_color   = s_axis_tdata_i[11:8];
    req.bg_color   = s_axis_tdata_i[15:12];
    req.cell_index = s_axis_tdata_i[26:16];
  end

  tcw_engine #(
    .Columns (COLUMNS),
    .Rows    (ROWS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready)
  );

  // output register frees as the downstream takes its transfer
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.scrolled, out_q.cursor_col,
                            out_q.cursor_row, out_q.cell_data};

endmodule

// ----- dv/tb_text_console_writer.sv -----
// self-checking testbench for text_console_writer: directed table, then shaped random traffic
// depends on tcw_pkg and the text_console_writer rtl; needs nothing else
`timescale 1ns / 1ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int unsigned COLUMNS      = TCW_COLUMNS;
  localparam int unsigned ROWS         = TCW_ROWS;
  localparam int unsigned CELL_COUNT   = ROWS * COLUMNS;
  localparam int unsigned RANDOM_ITEMS = 900;
  // generous limit: every item a full scroll sweep under stalls stays well below it
  localparam int unsigned CYCLE_LIMIT  = 10_000_000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned HOLD_AT_A    = 240;
  localparam int unsigned HOLD_AT_B    = 640;
  localparam int unsigned MAX_REPORTS  = 10;

  // one request plus an optional hand-typed expectation
  typedef struct {
    req_t    item;
    bit      typed;
    result_t typed_result;
  } console_op_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [31:0] req_tdata = '0;
  logic [1:0]  req_tuser = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [31:0] res_tdata;

  // shadow copy of the screen and cursor, updated at every accepted request
  cell_t       shadow_screen [CELL_COUNT];
  int unsigned shadow_row;
  int unsigned shadow_col;

  result_t     expected_results [$];
  console_op_t directed_ops [$];
  console_op_t offered_op;

  int unsigned cycle_count     = 0;
  int unsigned accepted_count  = 0;
  int unsigned checked_count   = 0;
  int unsigned mismatch_count  = 0;
  int unsigned put_count       = 0;
  int unsigned scroll_count    = 0;
  int unsigned clear_count     = 0;
  int unsigned read_count      = 0;
  int unsigned oob_read_count  = 0;
  int unsigned line_left       = 0;
  int unsigned burst_left      = 0;
  bit          hold_pending    = 1'b0;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(req_valid),
    .s_axis_tready_o(req_ready),
    .s_axis_tdata_i (req_tdata),
    .s_axis_tuser_i (req_tuser),
    .m_axis_tvalid_o(res_valid),
    .m_axis_tready_i(res_ready),
    .m_axis_tdata_o (res_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still outstanding",
             cycle_count, expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // screen predictor: applies one request to the shadow state, returns the result
  // ---------------------------------------------------------------------------
  function automatic result_t apply_console_request(input req_t r);
    result_t     res;
    cell_t       read_back;
    logic        moved;
    int unsigned cell_pos;
    read_back = '0;
    moved     = 1'b0;
    case (r.req_type)
      REQ_PUT: begin
        put_count++;
        if (r.char_code == NEWLINE_CODE) begin
          shadow_col = 0;
          shadow_row++;
        end else begin
          cell_pos = shadow_row * COLUMNS + shadow_col;
          if (cell_pos < CELL_COUNT) begin
            shadow_screen[cell_pos] = {r.bg_color, r.fg_color, r.char_code};
          end
          shadow_col++;
        end
        // line end wraps to the next row
        if (shadow_col >= COLUMNS) begin
          shadow_col = 0;
          shadow_row++;
        end
        // past the bottom: shift rows up, blank the bottom row but keep its bg nibble
        if (shadow_row >= ROWS) begin
          for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
            shadow_screen[i] = shadow_screen[i + COLUMNS];
          end
          for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
            shadow_screen[i] = (shadow_screen[i] & BG_KEEP_MASK) | cell_t'(SPACE_CODE);
          end
          shadow_row = ROWS - 1;
          moved      = 1'b1;
          scroll_count++;
        end
      end
      REQ_CLEAR: begin
        clear_count++;
        for (int i = 0; i < CELL_COUNT; i++) begin
          shadow_screen[i] = {r.bg_color, 4'h0, SPACE_CODE};
        end
        shadow_row = 0;
        shadow_col = 0;
      end
      REQ_READ: begin
        read_count++;
        if (r.cell_index < CELL_COUNT) begin
          read_back = shadow_screen[r.cell_index];
        end else begin
          oob_read_count++;
        end
      end
      default: begin
        // unused request code leaves everything alone
      end
    endcase
    res.cell_data  = read_back;
    res.cursor_row = shadow_row[4:0];
    res.cursor_col = shadow_col[6:0];
    res.scrolled   = moved;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch %0d: %s", $realtime, mismatch_count, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // transfer monitor: results are checked before the same edge's request is
  // queued, a fresh request can never produce a result on its accepting edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    result_t predicted;
    if (rst_n && res_valid && res_ready) begin
      got.cell_data  = res_tdata[15:0];
      got.cursor_row = res_tdata[20:16];
      got.cursor_col = res_tdata[27:21];
      got.scrolled   = res_tdata[28];
      checked_count++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: cell %h row %0d col %0d scr %0b",
                                  got.cell_data, got.cursor_row, got.cursor_col, got.scrolled));
      end else begin
        want = expected_results.pop_front();
        if (got.cell_data !== want.cell_data || got.cursor_row !== want.cursor_row ||
            got.cursor_col !== want.cursor_col || got.scrolled !== want.scrolled) begin
          report_mismatch($sformatf(
            "expected cell %h row %0d col %0d scr %0b, got cell %h row %0d col %0d scr %0b",
            want.cell_data, want.cursor_row, want.cursor_col, want.scrolled,
            got.cell_data, got.cursor_row, got.cursor_col, got.scrolled));
        end
      end
    end
    if (rst_n && req_valid && req_ready) begin
      predicted = apply_console_request(offered_op.item);
      // hand-typed rows are checked against their own value, the shadow still advances
      expected_results.push_back(offered_op.typed ? offered_op.typed_result : predicted);
      accepted_count++;
      if (accepted_count == HOLD_AT_A || accepted_count == HOLD_AT_B) begin
        hold_pending = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: stall pattern that switches mode every so often, plus an
  // occasional long hold-off so the block backs up and stalls its input
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned beat;
    mode      = 0;
    mode_left = 0;
    beat      = 0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        res_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(30, 150);
        end
        mode_left--;
        beat++;
        case (mode)
          0:       res_ready <= 1'b1;
          1:       res_ready <= ($urandom_range(0, 1) == 0);
          2:       res_ready <= (beat % 4 == 0);
          default: res_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side: called at a falling edge, returns at a falling edge; sends in
  // bursts and, between bursts, may drop valid for a random gap
  task automatic offer_request(input console_op_t op);
    int unsigned gap;
    offered_op = op;
    req_valid <= 1'b1;
    req_tuser <= op.item.req_type;
    req_tdata <= {5'b0, op.item.cell_index, op.item.bg_color, op.item.fg_color,
                  op.item.char_code};
    do @(posedge clk_i); while (!req_ready);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic directed_row(input req_e kind, input logic [7:0] ch, input logic [3:0] fg,
                              input logic [3:0] bg, input logic [10:0] idx, input bit typed,
                              input cell_t c, input logic [4:0] row, input logic [6:0] col);
    console_op_t op;
    op.item.req_type          = kind;
    op.item.char_code         = ch;
    op.item.fg_color          = fg;
    op.item.bg_color          = bg;
    op.item.cell_index        = idx;
    op.typed                  = typed;
    op.typed_result.cell_data  = c;
    op.typed_result.cursor_row = row;
    op.typed_result.cursor_col = col;
    op.typed_result.scrolled   = 1'b0;
    directed_ops.push_back(op);
  endtask

  // random traffic shaped as lines of text: runs of characters ending in a
  // newline, some longer than a row so they wrap, mixed with reads, rare clears
  // and the odd unused request code
  function automatic console_op_t random_console_op();
    console_op_t op;
    int unsigned pick;
    int unsigned cursor_at;
    op.typed              = 1'b0;
    op.typed_result       = '0;
    op.item.char_code     = 8'($urandom_range(0, 255));
    op.item.fg_color      = 4'($urandom_range(0, 15));
    op.item.bg_color      = 4'($urandom_range(0, 15));
    op.item.cell_index    = 11'($urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      op.item.req_type = REQ_CLEAR;
    end else if (pick < 5) begin
      op.item.req_type = REQ_NONE;
    end else if (pick < 25) begin
      op.item.req_type = REQ_READ;
      cursor_at = shadow_row * COLUMNS + shadow_col;
      case ($urandom_range(0, 5))
        0:       op.item.cell_index = 11'($urandom_range(CELL_COUNT - COLUMNS, CELL_COUNT - 1));
        1, 2:    op.item.cell_index = 11'((cursor_at > 3) ? cursor_at - $urandom_range(1, 3) : 0);
        3:       op.item.cell_index = 11'($urandom_range(CELL_COUNT, 2047));
        default: op.item.cell_index = 11'($urandom_range(0, CELL_COUNT - 1));
      endcase
    end else begin
      op.item.req_type = REQ_PUT;
      if (line_left == 0) begin
        op.item.char_code = NEWLINE_CODE;
        case ($urandom_range(0, 4))
          0:       line_left = $urandom_range(0, 8);
          1, 2, 3: line_left = $urandom_range(0, COLUMNS - 1);
          default: line_left = $urandom_range(COLUMNS - 4, 2 * COLUMNS + 10);
        endcase
      end else begin
        line_left--;
      end
    end
    return op;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    shadow_row = 0;
    shadow_col = 0;
    foreach (shadow_screen[i]) shadow_screen[i] = '0;

    // directed table: kind, char, fg, bg, index, typed, cell, row, col
    directed_row(REQ_READ,  8'h00, 4'h0, 4'h0, 11'd0,    1, 16'h0000, 5'd0, 7'd0);
    directed_row(REQ_READ,  8'h00, 4'h0, 4'h0, 11'd1999, 1, 16'h0000, 5'd0, 7'd0);
    directed_row(REQ_READ,  8'hFF, 4'hF, 4'hF, 11'd2047, 1, 16'h0000, 5'd0, 7'd0);
    directed_row(REQ_NONE,  8'hFF, 4'hF, 4'hF, 11'd2047, 1, 16'h0000, 5'd0, 7'd0);
    directed_row(REQ_PUT,   8'h41, 4'hF, 4'hF, 11'd0,    1, 16'h0000, 5'd0, 7'd1);
    directed_row(REQ_READ,  8'h00, 4'h0, 4'h0, 11'd0,    1, 16'hFF41, 5'd0, 7'd1);
    directed_row(REQ_PUT,   8'h00, 4'h0, 4'h0, 11'd0,    0, '0, '0, '0);
    directed_row(REQ_PUT,   8'hFF, 4'h5, 4'hA, 11'd0,    0, '0, '0, '0);
    directed_row(REQ_PUT,   NEWLINE_CODE, 4'h3, 4'h3, 11'd0, 1, 16'h0000, 5'd1, 7'd0);
    directed_row(REQ_READ,  8'h00, 4'h0, 4'h0, 11'd2,    0, '0, '0, '0);
    directed_row(REQ_READ,  8'h00, 4'h0, 4'h0, 11'd80,   0, '0, '0, '0);
    directed_row(REQ_PUT,   8'h7E, 4'hF, 4'h0, 11'd2047, 0, '0, '0, '0);
    directed_row(REQ_NONE,  8'h00, 4'h0, 4'h0, 11'd0,    0, '0, '0, '0);
    // clear never scrolls and homes the cursor
    directed_row(REQ_CLEAR, 8'hFF, 4'hF, 4'hF, 11'd2047, 1, 16'h0000, 5'd0, 7'd0);
    directed_row(REQ_READ,  8'h00, 4'h0, 4'h0, 11'd1999, 1, 16'hF020, 5'd0, 7'd0);
    directed_row(REQ_READ,  8'h00, 4'h0, 4'h0, 11'd2000, 1, 16'h0000, 5'd0, 7'd0);
    directed_row(REQ_READ,  8'h00, 4'h0, 4'h0, 11'd1,    1, 16'hF020, 5'd0, 7'd0);
    directed_row(REQ_PUT,   NEWLINE_CODE, 4'hF, 4'hF, 11'd0, 1, 16'h0000, 5'd1, 7'd0);
    directed_row(REQ_PUT,   8'h20, 4'h9, 4'h6, 11'd0,    0, '0, '0, '0);
    directed_row(REQ_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0,    1, 16'h0000, 5'd0, 7'd0);
    directed_row(REQ_READ,  8'h00, 4'h0, 4'h0, 11'd0,    1, 16'h0020, 5'd0, 7'd0);
    directed_row(REQ_READ,  8'h00, 4'h0, 4'h0, 11'd1024, 1, 16'h0020, 5'd0, 7'd0);
    // colored screen, then run the cursor off the bottom so it scrolls a few times
    directed_row(REQ_CLEAR, 8'h00, 4'h0, 4'h5, 11'd0,    1, 16'h0000, 5'd0, 7'd0);
    directed_row(REQ_PUT,   8'h5A, 4'h2, 4'hC, 11'd0,    0, '0, '0, '0);
    for (int n = 0; n < 27; n++) begin
      directed_row(REQ_PUT, NEWLINE_CODE, 4'h0, 4'h0, 11'd0, 0, '0, '0, '0);
    end
    directed_row(REQ_READ,  8'h00, 4'h0, 4'h0, 11'd1999, 0, '0, '0, '0);
    directed_row(REQ_READ,  8'h00, 4'h0, 4'h0, 11'd1920, 0, '0, '0, '0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    foreach (directed_ops[i]) offer_request(directed_ops[i]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      offer_request(random_console_op());
    end
    req_valid <= 1'b0;

    // every request gives one result, so once the queue drains only stray
    // results remain to be caught
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);

    $display("covered %0d requests: %0d puts, %0d scrolls, %0d clears, %0d reads (%0d out of range)",
             accepted_count, put_count, scroll_count, clear_count, read_count, oob_read_count);
    $display("checked %0d results in %0d cycles, %0d mismatches",
             checked_count, cycle_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
